FILE: rtl/core/pst_pkg.sv
// Shared types and constants for the PL/SQL stream tokenizer.
`default_nettype none

package pst_pkg;

    // Input transaction: one source byte and its end-of-text flag.
    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } t_byte_in;

    // Output transaction: one token.
    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        integer_literal;
        logic [31:0] literal_value;
        logic        last_of_run;
    } t_token_out;

    // Most tokens one source byte can release.
    localparam int unsigned SLOTS = 3;

    // Tokens released by one byte, packed from slot 0 upward.
    typedef struct packed {
        logic [1:0]                num;
        t_token_out [SLOTS-1:0]    tok;
    } t_tok_set;

    typedef enum logic [4:0] {
        K_EOF     = 5'd0,
        K_ILLEGAL = 5'd1,
        K_NUM     = 5'd2,
        K_STR     = 5'd3,
        K_ID      = 5'd4,
        K_ASSIGN  = 5'd5,
        K_DOTDOT  = 5'd6,
        K_LP      = 5'd7,
        K_RP      = 5'd8,
        K_COMMA   = 5'd9,
        K_SEMI    = 5'd10,
        K_PLUS    = 5'd11,
        K_MINUS   = 5'd12,
        K_STAR    = 5'd13,
        K_SLASH   = 5'd14,
        K_PCT     = 5'd15,
        K_CONCAT  = 5'd16,
        K_EQ      = 5'd17,
        K_NE      = 5'd18,
        K_LT      = 5'd19,
        K_LE      = 5'd20,
        K_GT      = 5'd21,
        K_GE      = 5'd22
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_MINUS  = 4'd1,
        M_SLASH  = 4'd2,
        M_LINE   = 4'd3,
        M_BLOCK  = 4'd4,
        M_BSTAR  = 4'd5,
        M_IDENT  = 4'd6,
        M_INT    = 4'd7,
        M_DOT    = 4'd8,
        M_FRAC   = 4'd9,
        M_EXP    = 4'd10,
        M_EXPDIG = 4'd11,
        M_STR    = 4'd12,
        M_SQUOTE = 4'd13,
        M_OP     = 4'd14
    } t_mode;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_LP     = 8'h28;
    localparam logic [7:0] CH_RP     = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;

endpackage

`default_nettype wire

FILE: rtl/core/pst_lexer.sv
// Lexer state and per-byte token decode for the PL/SQL stream tokenizer.
`default_nettype none

module pst_lexer #(
    parameter int OFFSET_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  pst_pkg::t_byte_in i_byte,
    output pst_pkg::t_tok_set o_set
);
    import pst_pkg::*;

    t_mode                  r_mode,   n_mode;
    logic [OFFSET_BITS-1:0] r_pos,    n_pos;
    logic [OFFSET_BITS-1:0] r_origin, n_origin;
    logic [15:0]            r_count,  n_count;
    logic [7:0]             r_held,   n_held;
    logic [31:0]            r_accum,  n_accum;
    logic                   r_frac,   n_frac;

    logic [7:0]             c;
    logic                   do_frac;
    logic                   do_idle;
    logic                   op_hit;
    t_kind                  op_kind;
    logic [35:0]            mac;
    logic [31:0]            accum_sat;
    t_token_out [3:0]       cand;
    logic [3:0]             cand_v;
    logic [2:0]             fill;
    t_token_out [SLOTS-1:0] slots;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= CH_ZERO) && (ch <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
    endfunction

    function automatic logic id_first(input logic [7:0] ch);
        return is_alpha(ch) || (ch == CH_UNDER);
    endfunction

    function automatic logic id_more(input logic [7:0] ch);
        return is_alpha(ch) || is_digit(ch) || (ch == CH_UNDER) || (ch == CH_DOLLAR);
    endfunction

    function automatic logic is_exp(input logic [7:0] ch);
        return (ch == CH_LO_E) || (ch == CH_UP_E);
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [1:0] b);
        logic [16:0] s;
        s = {1'b0, a} + 17'(b);
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic t_token_out mk(input t_kind k, input logic [15:0] st,
                                      input logic [15:0] len, input logic isint,
                                      input logic [31:0] val);
        t_token_out t;
        t.token_kind      = k;
        t.token_start     = st;
        t.token_length    = len;
        t.integer_literal = isint;
        t.literal_value   = val;
        t.last_of_run     = 1'b0;
        return t;
    endfunction

    function automatic t_token_out num_tok(input logic [15:0] st, input logic [15:0] len,
                                           input logic frac, input logic [31:0] val);
        return mk(K_NUM, st, len, !frac, frac ? 32'd0 : val);
    endfunction

    // Kind of a held operator byte that found no partner.
    function automatic t_kind single_kind(input logic [7:0] h);
        t_kind k;
        if (h == CH_LT) begin
            k = K_LT;
        end else if (h == CH_GT) begin
            k = K_GT;
        end else begin
            k = K_ILLEGAL;
        end
        return k;
    endfunction

    function automatic t_kind char_kind(input logic [7:0] ch);
        t_kind k;
        unique case (ch)
            CH_LP:    k = K_LP;
            CH_RP:    k = K_RP;
            CH_COMMA: k = K_COMMA;
            CH_SEMI:  k = K_SEMI;
            CH_PLUS:  k = K_PLUS;
            CH_STAR:  k = K_STAR;
            CH_PCT:   k = K_PCT;
            CH_EQ:    k = K_EQ;
            default:  k = K_ILLEGAL;
        endcase
        return k;
    endfunction

    assign c = i_byte.byte_in;

    // Saturating accum * 10 + digit.
    always_comb begin
        mac       = ({4'd0, r_accum} << 3) + ({4'd0, r_accum} << 1) + 36'(c[3:0]);
        accum_sat = (mac[35:32] != 4'd0) ? 32'hFFFF_FFFF : mac[31:0];
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos + OFFSET_BITS'(1);
        n_origin = r_origin;
        n_count  = r_count;
        n_held   = r_held;
        n_accum  = r_accum;
        n_frac   = r_frac;
        cand     = '0;
        cand_v   = '0;
        do_frac  = 1'b0;
        do_idle  = 1'b0;
        op_hit   = 1'b0;
        op_kind  = K_ILLEGAL;

        // Candidate 0: token closed by the current mode.
        unique case (r_mode)
            M_MINUS: begin
                if (c == CH_MINUS) begin
                    n_mode = M_LINE;
                end else begin
                    cand[0] = mk(K_MINUS, 16'(r_origin), 16'd1, 1'b0, 32'd0);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_SLASH: begin
                if (c == CH_STAR) begin
                    n_mode = M_BLOCK;
                end else begin
                    cand[0] = mk(K_SLASH, 16'(r_origin), 16'd1, 1'b0, 32'd0);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_LINE: begin
                if (c == CH_NL) begin
                    n_mode = M_IDLE;
                end
            end
            M_BLOCK: begin
                if (c == CH_STAR) begin
                    n_mode = M_BSTAR;
                end
            end
            M_BSTAR: begin
                if (c == CH_SLASH) begin
                    n_mode = M_IDLE;
                end else if (c != CH_STAR) begin
                    n_mode = M_BLOCK;
                end
            end
            M_IDENT: begin
                if (id_more(c)) begin
                    n_count = sat_add(r_count, 2'd1);
                end else begin
                    cand[0] = mk(K_ID, 16'(r_origin), r_count, 1'b0, 32'd0);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit(c)) begin
                    n_accum = accum_sat;
                    n_count = sat_add(r_count, 2'd1);
                end else if (c == CH_DOT) begin
                    n_mode = M_DOT;
                end else if (is_exp(c)) begin
                    n_frac  = 1'b1;
                    n_count = sat_add(r_count, 2'd1);
                    n_mode  = M_EXP;
                end else begin
                    cand[0] = num_tok(16'(r_origin), r_count, r_frac, r_accum);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_DOT: begin
                if (c == CH_DOT) begin
                    // Integer followed by the range operator.
                    cand[0] = num_tok(16'(r_origin), r_count, r_frac, r_accum);
                    cand_v[0] = 1'b1;
                    cand[1] = mk(K_DOTDOT, 16'(r_pos - OFFSET_BITS'(1)), 16'd2, 1'b0, 32'd0);
                    cand_v[1] = 1'b1;
                    n_mode = M_IDLE;
                end else begin
                    n_frac  = 1'b1;
                    n_count = sat_add(r_count, 2'd1);
                    n_mode  = M_FRAC;
                    do_frac = 1'b1;
                end
            end
            M_FRAC: begin
                do_frac = 1'b1;
            end
            M_EXP: begin
                if ((c == CH_PLUS) || (c == CH_MINUS) || is_digit(c)) begin
                    n_count = sat_add(r_count, 2'd1);
                    n_mode  = M_EXPDIG;
                end else begin
                    cand[0] = num_tok(16'(r_origin), r_count, r_frac, r_accum);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_EXPDIG: begin
                if (is_digit(c)) begin
                    n_count = sat_add(r_count, 2'd1);
                end else begin
                    cand[0] = num_tok(16'(r_origin), r_count, r_frac, r_accum);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_STR: begin
                if (c == CH_QUOTE) begin
                    n_mode = M_SQUOTE;
                end else begin
                    n_count = sat_add(r_count, 2'd1);
                end
            end
            M_SQUOTE: begin
                if (c == CH_QUOTE) begin
                    // Doubled quote stays inside the string.
                    n_count = sat_add(r_count, 2'd2);
                    n_mode  = M_STR;
                end else begin
                    cand[0] = mk(K_STR, 16'(r_origin), r_count, 1'b0, 32'd0);
                    cand_v[0] = 1'b1;
                    do_idle = 1'b1;
                end
            end
            M_OP: begin
                if ((r_held == CH_DOT) && is_digit(c)) begin
                    // Leading dot opens a fraction.
                    n_mode  = M_FRAC;
                    n_count = 16'd2;
                    n_accum = 32'd0;
                    n_frac  = 1'b1;
                end else begin
                    if ((r_held == CH_DOT) && (c == CH_DOT)) begin
                        op_hit = 1'b1; op_kind = K_DOTDOT;
                    end
                    if ((r_held == CH_COLON) && (c == CH_EQ)) begin
                        op_hit = 1'b1; op_kind = K_ASSIGN;
                    end
                    if ((r_held == CH_BAR) && (c == CH_BAR)) begin
                        op_hit = 1'b1; op_kind = K_CONCAT;
                    end
                    if ((r_held == CH_LT) && (c == CH_EQ)) begin
                        op_hit = 1'b1; op_kind = K_LE;
                    end
                    if ((r_held == CH_LT) && (c == CH_GT)) begin
                        op_hit = 1'b1; op_kind = K_NE;
                    end
                    if ((r_held == CH_GT) && (c == CH_EQ)) begin
                        op_hit = 1'b1; op_kind = K_GE;
                    end
                    if ((r_held == CH_BANG) && (c == CH_EQ)) begin
                        op_hit = 1'b1; op_kind = K_NE;
                    end
                    if (op_hit) begin
                        cand[0] = mk(op_kind, 16'(r_origin), 16'd2, 1'b0, 32'd0);
                        cand_v[0] = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        cand[0] = mk(single_kind(r_held), 16'(r_origin), 16'd1, 1'b0, 32'd0);
                        cand_v[0] = 1'b1;
                        do_idle = 1'b1;
                    end
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        // Fraction digits, shared by the fraction mode and a dot after digits.
        if (do_frac) begin
            if (is_digit(c)) begin
                n_count = sat_add(n_count, 2'd1);
            end else if (is_exp(c)) begin
                n_count = sat_add(n_count, 2'd1);
                n_mode  = M_EXP;
            end else begin
                cand[0] = num_tok(16'(r_origin), n_count, n_frac, n_accum);
                cand_v[0] = 1'b1;
                do_idle = 1'b1;
            end
        end

        // Candidate 1: byte seen between tokens.
        if (do_idle) begin
            n_mode = M_IDLE;
            if (!is_space(c)) begin
                priority if (c == CH_MINUS) begin
                    n_mode = M_MINUS; n_origin = r_pos; n_count = 16'd1;
                end else if (c == CH_SLASH) begin
                    n_mode = M_SLASH; n_origin = r_pos; n_count = 16'd1;
                end else if (id_first(c)) begin
                    n_mode = M_IDENT; n_origin = r_pos; n_count = 16'd1;
                end else if (is_digit(c)) begin
                    n_mode = M_INT; n_origin = r_pos; n_count = 16'd1;
                    n_accum = 32'(c[3:0]);
                    n_frac = 1'b0;
                end else if (c == CH_QUOTE) begin
                    n_mode = M_STR; n_origin = r_pos + OFFSET_BITS'(1); n_count = 16'd0;
                end else if ((c == CH_DOT) || (c == CH_COLON) || (c == CH_BAR) ||
                             (c == CH_LT) || (c == CH_GT) || (c == CH_BANG)) begin
                    n_mode = M_OP; n_origin = r_pos; n_count = 16'd1; n_held = c;
                end else begin
                    cand[1] = mk(char_kind(c), 16'(r_pos), 16'd1, 1'b0, 32'd0);
                    cand_v[1] = 1'b1;
                end
            end
        end

        // Candidates 2 and 3: flush the pending token, then close the run.
        if (i_byte.last_byte) begin
            unique case (n_mode)
                M_MINUS: begin
                    cand[2] = mk(K_MINUS, 16'(n_origin), 16'd1, 1'b0, 32'd0);
                    cand_v[2] = 1'b1;
                end
                M_SLASH: begin
                    cand[2] = mk(K_SLASH, 16'(n_origin), 16'd1, 1'b0, 32'd0);
                    cand_v[2] = 1'b1;
                end
                M_IDENT: begin
                    cand[2] = mk(K_ID, 16'(n_origin), n_count, 1'b0, 32'd0);
                    cand_v[2] = 1'b1;
                end
                M_INT, M_FRAC, M_EXP, M_EXPDIG: begin
                    cand[2] = num_tok(16'(n_origin), n_count, n_frac, n_accum);
                    cand_v[2] = 1'b1;
                end
                M_DOT: begin
                    // Trailing dot counts into a non-integer number.
                    cand[2] = num_tok(16'(n_origin), sat_add(n_count, 2'd1), 1'b1, n_accum);
                    cand_v[2] = 1'b1;
                end
                M_STR, M_SQUOTE: begin
                    cand[2] = mk(K_STR, 16'(n_origin), n_count, 1'b0, 32'd0);
                    cand_v[2] = 1'b1;
                end
                M_OP: begin
                    cand[2] = mk(single_kind(n_held), 16'(n_origin), 16'd1, 1'b0, 32'd0);
                    cand_v[2] = 1'b1;
                end
                default: begin
                    cand_v[2] = 1'b0;
                end
            endcase
            cand[3] = mk(K_EOF, 16'(n_pos), 16'd0, 1'b0, 32'd0);
            cand_v[3] = 1'b1;
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_origin = '0;
            n_count  = '0;
            n_held   = '0;
            n_accum  = '0;
            n_frac   = 1'b0;
        end
    end

    // Pack candidates into slots in order; drop any beyond the slot count.
    always_comb begin
        fill  = '0;
        slots = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (fill < 3'(SLOTS))) begin
                slots[fill[1:0]] = cand[i];
                fill = fill + 3'd1;
            end
        end
        if (fill != 3'd0) begin
            slots[2'(fill - 3'd1)].last_of_run = 1'b1;
        end
    end

    assign o_set.num = fill[1:0];
    assign o_set.tok = slots;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_origin <= '0;
            r_count  <= '0;
            r_held   <= '0;
            r_accum  <= '0;
            r_frac   <= 1'b0;
        end else if (i_take) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_count  <= n_count;
            r_held   <= n_held;
            r_accum  <= n_accum;
            r_frac   <= n_frac;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pst_tok_queue.sv
// Four-entry token queue that takes up to three tokens and gives one per cycle while i_ready is high.
`default_nettype none

module pst_tok_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pst_pkg::t_tok_set   i_set,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output pst_pkg::t_token_out o_tok
);
    import pst_pkg::*;

    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    t_token_out             r_q [QDEPTH];
    logic [PTR_W-1:0]       r_wptr, n_wptr;
    logic [PTR_W-1:0]       r_rptr, n_rptr;
    logic [CNT_W-1:0]       r_cnt,  n_cnt;
    logic [PTR_W-1:0]       woff [QDEPTH];
    logic [1:0]             push_num;
    logic                   pop;

    assign push_num = i_push ? i_set.num : 2'd0;
    assign pop      = o_valid && i_ready;
    assign o_valid  = (r_cnt != '0);
    assign o_room   = (r_cnt <= CNT_W'(QDEPTH - int'(SLOTS)));
    assign o_tok    = r_q[r_rptr];

    // Slot of the incoming set that lands in each entry.
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            woff[i] = PTR_W'(i) - r_wptr;
        end
    end

    always_comb begin
        n_wptr = r_wptr + PTR_W'(push_num);
        n_rptr = r_rptr + PTR_W'(pop);
        n_cnt  = r_cnt + CNT_W'(push_num) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (woff[i] < PTR_W'(push_num)) begin
                r_q[i] <= i_set.tok[woff[i][1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/plsql_stream_tokenizer_top.sv
// Top level of the PL/SQL stream tokenizer: byte lexer feeding a token queue.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------
//   source  | in        | i_in_valid / o_in_ready    | i_in_data  (t_byte_in)
//   tokens  | out       | o_out_valid / i_out_ready  | o_out_data (t_token_out)
//
// One source byte is taken per cycle while o_in_ready is high; its tokens (up
// to three) are in the queue on the next cycle. o_in_ready is high while at
// most one token waits in the four-entry queue, so a byte that releases two or
// three tokens holds the source while the queue drains, one token per cycle
// whenever i_out_ready is high. No clearing pass follows reset.
`default_nettype none

module plsql_stream_tokenizer_top #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pst_pkg::t_byte_in   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pst_pkg::t_token_out o_out_data
);
    import pst_pkg::*;

    logic     in_fire;
    t_tok_set w_set;

    assign in_fire = i_in_valid && o_in_ready;

    pst_lexer #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_lexer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (in_fire),
        .i_byte (i_in_data),
        .o_set  (w_set)
    );

    pst_tok_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (in_fire),
        .i_set  (w_set),
        .o_room (o_in_ready),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_tok  (o_out_data)
    );

`ifndef SYNTHESIS
    // A final byte always releases at least the end-of-text token.
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.last_byte |-> w_set.num != 2'd0)
        else $error("final byte released no token");

    a_last_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_in_data.last_byte |=> o_out_valid)
        else $error("no token pending after final byte");

    // Back-pressure on the source only while tokens are waiting.
    a_stall_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("source stalled with empty queue");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("token pending right after reset");
`endif

endmodule

`default_nettype wire
